// ----- design/ansi_sgr_colour_filter_core_assert.svh -----
// assertion macros shared by the colour filter rtl
// expects a clock named clk and a reset named rst in the including scope
`ifndef ANSI_SGR_COLOUR_FILTER_CORE_ASSERT_SVH
`define ANSI_SGR_COLOUR_FILTER_CORE_ASSERT_SVH

// checked only outside reset
`define ASGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASGR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/asgr_pkg.sv -----
// constants, parser state types and reset values for the sgr colour filter
// no dependencies
`default_nettype none

package asgr_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'd27;
  localparam logic [7:0] CSI_OPEN   = 8'h5B;
  localparam logic [7:0] FINAL_LOW  = 8'h40;
  localparam logic [7:0] FINAL_HIGH = 8'h7E;
  localparam logic [7:0] SGR_FINAL  = 8'h6D;
  localparam logic [7:0] DIGIT_LOW  = 8'h30;
  localparam logic [7:0] DIGIT_HIGH = 8'h39;
  localparam logic [7:0] PARAM_SEP  = 8'h3B;

  localparam logic [9:0] CODE_FOREGROUND = 10'd38;
  localparam logic [9:0] CODE_TRUECOLOR  = 10'd2;

  // separator counts: first two params are codes, next three are channels
  localparam logic [2:0] PARAM_FIRST  = 3'd0;
  localparam logic [2:0] PARAM_SECOND = 3'd1;
  localparam logic [2:0] PARAM_RED    = 3'd2;
  localparam logic [2:0] PARAM_GREEN  = 3'd3;
  localparam logic [2:0] PARAM_BLUE   = 3'd4;
  localparam logic [2:0] PARAM_MAX    = 3'd5;

  localparam logic [23:0] RESET_COLOUR = 24'h6495ED;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESC    = 3'b010,
    MODE_CSI    = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [9:0]  acc;
    logic [2:0]  count;
    logic        still_valid;
    logic [23:0] gather;
    logic [23:0] fg;
  } parse_state_t;

  localparam parse_state_t RESET_STATE = '{
    mode:        MODE_NORMAL,
    acc:         10'd0,
    count:       3'd0,
    still_valid: 1'b1,
    gather:      24'd0,
    fg:          RESET_COLOUR
  };

endpackage

`default_nettype wire

// ----- design/asgr_channels.sv -----
// valid/ready channel interfaces for text input and coloured character output
// uses no package
`default_nettype none

interface asgr_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface asgr_char_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_byte;
  logic [23:0] colour;

  modport source (output valid, output char_byte, output colour, input ready);
  modport sink (input valid, input char_byte, input colour, output ready);
endinterface

`default_nettype wire

// ----- design/ansi_sgr_colour_filter_core.sv -----
// top level of the sgr true-colour filter: input register, parser, result register
// depends on asgr_pkg, asgr_channels, asgr_parser and the assertion header
`default_nettype none

// Filters a text byte stream: escape sequences are stripped, every other byte
// leaves on char_out tagged with the current 24-bit foreground colour. A CSI
// sequence of the exact form 38;2;R;G;B ending in 'm' sets the foreground
// (low 8 bits of each channel); any other sequence is swallowed without effect.
// The foreground resets to 0x6495ED. Throughput is one item per cycle while
// char_out is not stalled: an accepted item sits in the input register while the
// parser works on it, and a passed byte then moves to the result register, which
// drives char_out. Bytes that produce no output (escape and sequence bytes) retire
// even while char_out is stalled; a printable byte waits in the input register
// only while the result register is full and not being taken.
module ansi_sgr_colour_filter_core (
  input wire logic    clk,
  input wire logic    rst,
  asgr_text_if.sink   text_in,
  asgr_char_if.source char_out
);

  `include "ansi_sgr_colour_filter_core_assert.svh"

  // input register
  logic       stage_v;
  logic [7:0] stage_byte;
  logic       stage_eot;

  // parser state
  asgr_pkg::parse_state_t st;
  asgr_pkg::parse_state_t st_next;
  logic                   emit;

  // result register
  logic        out_v;
  logic [7:0]  out_byte;
  logic [23:0] out_colour;

  logic out_free;
  logic stage_adv;

  asgr_parser u_parser (
    .cur         (st),
    .text_byte   (stage_byte),
    .end_of_text (stage_eot),
    .nxt         (st_next),
    .emit        (emit)
  );

  // a byte with no result never needs the output slot
  assign out_free      = !out_v || char_out.ready;
  assign stage_adv     = stage_v && (!emit || out_free);
  assign text_in.ready = !stage_v || stage_adv;

  assign char_out.valid     = out_v;
  assign char_out.char_byte = out_byte;
  assign char_out.colour    = out_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
      out_v   <= 1'b0;
      st      <= asgr_pkg::RESET_STATE;
    end else begin
      if (text_in.ready) stage_v <= text_in.valid;
      if (stage_adv) st <= st_next;
      if (stage_adv && emit) begin
        out_v <= 1'b1;
      end else if (char_out.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      stage_byte <= text_in.text_byte;
      stage_eot  <= text_in.end_of_text;
    end
    if (stage_adv && emit) begin
      out_byte   <= stage_byte;
      out_colour <= st.fg;
    end
  end

  // state only moves when the staged item retires
  `ASGR_ASSERT(a_state_holds, !stage_adv |=> $stable(st), "parser state moved without an item")
  // a passed byte carries the colour in force when it was parsed
  `ASGR_ASSERT(a_emit_colour, stage_adv && emit |=> out_v && (out_colour == $past(st.fg)),
    "emitted item lost or wrong colour")
  // end of text always leaves the parser in normal mode
  `ASGR_ASSERT(a_eot_normal, stage_adv && stage_eot |=> st.mode == asgr_pkg::MODE_NORMAL,
    "parser not back to normal after end of text")
  // a stalled printable byte stays in the input register
  `ASGR_ASSERT(a_stall_holds, stage_v && emit && !out_free |=> stage_v && $stable(stage_byte),
    "stalled item dropped")
  `ASGR_ASSERT(a_count_range, st.count <= asgr_pkg::PARAM_MAX,
    "parameter count out of range")
  // reset leaves both registers empty
  `ASGR_ASSERT_ALWAYS(a_reset_empty, rst |=> !stage_v && !out_v,
    "registers not empty after reset")

endmodule

`default_nettype wire

// ----- design/asgr_parser.sv -----
// next-state logic of the escape sequence parser, one byte per evaluation
// depends on asgr_pkg
`default_nettype none

module asgr_parser (
  input  var asgr_pkg::parse_state_t cur,
  input  wire logic [7:0]            text_byte,
  input  wire logic                  end_of_text,
  output asgr_pkg::parse_state_t     nxt,
  output logic                       emit
);

  logic [3:0] digit;
  logic [9:0] acc_scaled;
  logic       is_final;
  logic       is_digit;

  assign digit      = 4'(text_byte - asgr_pkg::DIGIT_LOW);
  // acc * 10 + digit, wrapping modulo 1024
  assign acc_scaled = {cur.acc[6:0], 3'b000} + {cur.acc[8:0], 1'b0} + {6'd0, digit};
  assign is_final   = (text_byte >= asgr_pkg::FINAL_LOW) && (text_byte <= asgr_pkg::FINAL_HIGH);
  assign is_digit   = (text_byte >= asgr_pkg::DIGIT_LOW) && (text_byte <= asgr_pkg::DIGIT_HIGH);

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    unique case (cur.mode)
      asgr_pkg::MODE_ESC: begin
        if (text_byte == asgr_pkg::CSI_OPEN) begin
          nxt.mode        = asgr_pkg::MODE_CSI;
          nxt.acc         = 10'd0;
          nxt.count       = asgr_pkg::PARAM_FIRST;
          nxt.still_valid = 1'b1;
          nxt.gather      = 24'd0;
        end else begin
          nxt.mode = asgr_pkg::MODE_NORMAL;
        end
      end
      asgr_pkg::MODE_CSI: begin
        priority if (is_final) begin
          if ((text_byte == asgr_pkg::SGR_FINAL) && cur.still_valid &&
              (cur.count == asgr_pkg::PARAM_BLUE)) begin
            nxt.fg = {cur.gather[15:0], cur.acc[7:0]};
          end
          nxt.mode = asgr_pkg::MODE_NORMAL;
        end else if (is_digit) begin
          nxt.acc = acc_scaled;
          // more digits never lower the value, so drop the match early
          if ((cur.count == asgr_pkg::PARAM_FIRST) && (acc_scaled > asgr_pkg::CODE_FOREGROUND))
            nxt.still_valid = 1'b0;
          if ((cur.count == asgr_pkg::PARAM_SECOND) && (acc_scaled > asgr_pkg::CODE_TRUECOLOR))
            nxt.still_valid = 1'b0;
        end else if (text_byte == asgr_pkg::PARAM_SEP) begin
          priority if (cur.count == asgr_pkg::PARAM_FIRST) begin
            if (cur.acc != asgr_pkg::CODE_FOREGROUND) nxt.still_valid = 1'b0;
          end else if (cur.count == asgr_pkg::PARAM_SECOND) begin
            if (cur.acc != asgr_pkg::CODE_TRUECOLOR) nxt.still_valid = 1'b0;
          end else if ((cur.count == asgr_pkg::PARAM_RED) ||
                       (cur.count == asgr_pkg::PARAM_GREEN)) begin
            nxt.gather = {cur.gather[15:0], cur.acc[7:0]};
          end else begin
            nxt.still_valid = 1'b0;
          end
          nxt.acc = 10'd0;
          if (cur.count < asgr_pkg::PARAM_MAX) nxt.count = cur.count + 3'd1;
        end else begin
          nxt.still_valid = 1'b0;
        end
      end
      default: begin
        if (text_byte == asgr_pkg::ESC_BYTE) begin
          nxt.mode = asgr_pkg::MODE_ESC;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    if (end_of_text) nxt.mode = asgr_pkg::MODE_NORMAL;
  end

endmodule

`default_nettype wire

// ----- tb/tb_ansi_sgr_colour_filter_core.sv -----
// self-checking testbench for the ansi sgr true-colour filter core
// depends on asgr_pkg, the asgr_channels interfaces and the core rtl
`timescale 1ns / 100ps

module tb_ansi_sgr_colour_filter_core;

  // one coloured character as it leaves the core
  typedef struct packed {
    logic [7:0]  ch;
    logic [23:0] colour;
  } coloured_char_t;

  // receiver ready patterns
  typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} rx_pattern_t;

  localparam int RANDOM_ITEMS = 550;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst;

  asgr_text_if text_if();
  asgr_char_if char_if();

  ansi_sgr_colour_filter_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_if),
    .char_out (char_if)
  );

  always #10 clk = ~clk;

  // shadow of the parser state, advanced on every accepted item
  asgr_pkg::parse_state_t shadow;
  // characters the core still owes us, oldest first
  coloured_char_t pending_chars[$];
  // byte sequence under construction for the random stream
  logic [7:0]     seq_buf[$];

  int          mismatches = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          tx_gappy = 1'b0;
  rx_pattern_t rx_pattern = RX_FREE;
  logic [7:0]  rx_phase = 8'd0;

  // append one byte to the sequence under construction
  task automatic add_seq_byte(input logic [7:0] b);
    seq_buf.insert(seq_buf.size(), b);
  endtask

  // ---------------------------------------------------------------------------
  // parser prediction
  // ---------------------------------------------------------------------------

  // close one parameter at a ';': the first two must be 38 and 2, the next
  // two are shifted into the gathered colour, any further one kills the match
  task automatic close_param();
    if (shadow.count == asgr_pkg::PARAM_FIRST) begin
      if (shadow.acc != asgr_pkg::CODE_FOREGROUND) shadow.still_valid = 1'b0;
    end else if (shadow.count == asgr_pkg::PARAM_SECOND) begin
      if (shadow.acc != asgr_pkg::CODE_TRUECOLOR) shadow.still_valid = 1'b0;
    end else if (shadow.count <= asgr_pkg::PARAM_GREEN) begin
      shadow.gather = {shadow.gather[15:0], shadow.acc[7:0]};
    end else begin
      shadow.still_valid = 1'b0;
    end
  endtask

  // one byte inside a csi sequence
  task automatic csi_step(input logic [7:0] b);
    if (b >= asgr_pkg::FINAL_LOW && b <= asgr_pkg::FINAL_HIGH) begin
      // blue is still in the accumulator when the final byte arrives
      if (b == asgr_pkg::SGR_FINAL && shadow.still_valid &&
          shadow.count == asgr_pkg::PARAM_BLUE)
        shadow.fg = {shadow.gather[15:0], shadow.acc[7:0]};
      shadow.mode = asgr_pkg::MODE_NORMAL;
    end else if (b >= asgr_pkg::DIGIT_LOW && b <= asgr_pkg::DIGIT_HIGH) begin
      // accumulator wraps at 10 bits, low byte stays exact
      shadow.acc = shadow.acc * 10'd10 + 10'(b - asgr_pkg::DIGIT_LOW);
      if (shadow.count == asgr_pkg::PARAM_FIRST && shadow.acc > asgr_pkg::CODE_FOREGROUND)
        shadow.still_valid = 1'b0;
      if (shadow.count == asgr_pkg::PARAM_SECOND && shadow.acc > asgr_pkg::CODE_TRUECOLOR)
        shadow.still_valid = 1'b0;
    end else if (b == asgr_pkg::PARAM_SEP) begin
      close_param();
      shadow.acc = 10'd0;
      if (shadow.count < asgr_pkg::PARAM_MAX) shadow.count = shadow.count + 3'd1;
    end else begin
      // stray byte: skipped, but the sequence can no longer match
      shadow.still_valid = 1'b0;
    end
  endtask

  // advance the shadow parser by one accepted item, queue any character it emits
  task automatic filter_byte(input logic [7:0] b, input logic eot);
    coloured_char_t c;
    case (shadow.mode)
      asgr_pkg::MODE_ESC: begin
        if (b == asgr_pkg::CSI_OPEN) begin
          shadow.mode        = asgr_pkg::MODE_CSI;
          shadow.acc         = 10'd0;
          shadow.count       = asgr_pkg::PARAM_FIRST;
          shadow.still_valid = 1'b1;
          shadow.gather      = 24'd0;
        end else begin
          shadow.mode = asgr_pkg::MODE_NORMAL;
        end
      end
      asgr_pkg::MODE_CSI: csi_step(b);
      default: begin
        if (b == asgr_pkg::ESC_BYTE) begin
          shadow.mode = asgr_pkg::MODE_ESC;
        end else begin
          c.ch     = b;
          c.colour = shadow.fg;
          pending_chars.insert(pending_chars.size(), c);
        end
      end
    endcase
    // end of text forces the parser back to plain text
    if (eot) shadow.mode = asgr_pkg::MODE_NORMAL;
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps, valid held between items
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [7:0] b, input logic eot);
    int gap;
    if (tx_gappy) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 5);
        text_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= eot;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    items_sent++;
    filter_byte(b, eot);
  endtask

  // send the built sequence; end of text sits on one byte if eot_at is in range
  task automatic send_seq(input int eot_at);
    foreach (seq_buf[i]) send_item(seq_buf[i], i == eot_at);
    seq_buf.delete();
  endtask

  // decimal parameter; negative means an empty parameter, sometimes zero padded
  task automatic push_number(input int v);
    string s;
    if (v < 0) return;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) add_seq_byte("0");
    for (int i = 0; i < s.len(); i++) add_seq_byte(s[i]);
  endtask

  // esc [ p0;p1;...;pn-1 final
  task automatic push_csi(input int params[6], input int n, input logic [7:0] fin);
    add_seq_byte(asgr_pkg::ESC_BYTE);
    add_seq_byte(asgr_pkg::CSI_OPEN);
    for (int i = 0; i < n; i++) begin
      if (i != 0) add_seq_byte(asgr_pkg::PARAM_SEP);
      push_number(params[i]);
    end
    add_seq_byte(fin);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: ready pattern and result check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    coloured_char_t want;
    rx_phase <= rx_phase + 8'd1;
    case (rx_pattern)
      RX_FREE:   char_if.ready <= 1'b1;
      RX_RANDOM: char_if.ready <= ($urandom_range(0, 3) != 0);
      // a long stall whenever rx_phase[5:3] reads 101, plus random drops elsewhere
      default:   char_if.ready <= (rx_phase[5:3] != 3'b101) && ($urandom_range(0, 2) != 0);
    endcase

    if (!rst && char_if.valid && char_if.ready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected char %h colour %h", char_if.char_byte, char_if.colour);
      end else begin
        want = pending_chars.pop_front();
        if (char_if.char_byte !== want.ch || char_if.colour !== want.colour) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: expected char %h colour %h, got char %h colour %h",
                     want.ch, want.colour, char_if.char_byte, char_if.colour);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // byte extremes pass through in the reset colour; zero byte is plain text
  task automatic test_plain_bytes();
    tx_gappy   = 1'b0;
    rx_pattern = RX_FREE;
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
  endtask

  // full true-colour set with an over-range red (low 8 bits kept) and an empty green
  task automatic test_colour_set();
    int p[6];
    tx_gappy   = 1'b1;
    rx_pattern = RX_RANDOM;
    p = '{38, 2, 1000, -1, 5, 0};
    push_csi(p, 5, asgr_pkg::SGR_FINAL);
    add_seq_byte("x");
    send_seq(-1);
  endtask

  // esc followed by anything but '[' swallows both bytes
  task automatic test_escape_drop();
    send_item(asgr_pkg::ESC_BYTE, 1'b0);
    send_item("X", 1'b0);
    send_item("y", 1'b0);
  endtask

  // end of text inside a sequence puts the parser back into plain text
  task automatic test_eot_in_csi();
    rx_pattern = RX_BURSTY;
    send_item(asgr_pkg::ESC_BYTE, 1'b0);
    send_item(asgr_pkg::CSI_OPEN, 1'b0);
    send_item("3", 1'b1);
    send_item("z", 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // random stream: mostly well-formed colour sequences, some broken ones, noise
  // ---------------------------------------------------------------------------

  task automatic test_random_stream();
    int         start;
    int         next_switch;
    int         kind;
    int         n;
    int         eot_at;
    int         p[6];
    logic [7:0] b;
    start       = items_sent;
    next_switch = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      // new idling phase now and then, including stretches with none
      if (items_sent >= next_switch) begin
        tx_gappy    = $urandom_range(0, 2) != 0;
        rx_pattern  = rx_pattern_t'($urandom_range(0, 2));
        next_switch = items_sent + $urandom_range(40, 120);
      end
      eot_at = -1;
      kind   = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          // plain text run
          n = $urandom_range(1, 6);
          repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == asgr_pkg::ESC_BYTE) b = 8'h00;
            add_seq_byte(b);
          end
          if ($urandom_range(0, 4) == 0) eot_at = n - 1;
        end
        2, 3, 4: begin
          // well-formed colour change, then a character to show it
          p = '{38, 2, 0, 0, 0, 0};
          for (int i = 2; i < 5; i++)
            case ($urandom_range(0, 5))
              0:       p[i] = -1;
              1:       p[i] = $urandom_range(256, 1023);
              2:       p[i] = 255;
              default: p[i] = $urandom_range(0, 255);
            endcase
          push_csi(p, 5, asgr_pkg::SGR_FINAL);
          add_seq_byte(8'($urandom_range(8'h20, 8'h7E)));
          if ($urandom_range(0, 15) == 0) eot_at = $urandom_range(0, seq_buf.size() - 1);
        end
        5, 6: begin
          // near miss: a good sequence with at most one thing changed, plus perhaps a stray byte
          p = '{38, 2, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255)};
          n = 5;
          b = asgr_pkg::SGR_FINAL;
          case ($urandom_range(0, 5))
            0: case ($urandom_range(0, 4))
                 0: p[0] = 48;
                 1: p[0] = 380;
                 2: p[0] = -1;
                 3: p[0] = 39;
                 default: p[0] = $urandom_range(0, 1023);
               endcase
            1: p[1] = ($urandom_range(0, 1) != 0) ? 20 : $urandom_range(0, 9);
            2: n = ($urandom_range(0, 1) != 0) ? 6 : $urandom_range(1, 4);
            3: b = 8'($urandom_range(asgr_pkg::FINAL_LOW, asgr_pkg::FINAL_HIGH));
            4: ;
            default: eot_at = $urandom_range(0, 10);
          endcase
          push_csi(p, n, b);
          // stray byte somewhere inside the parameters
          if ($urandom_range(0, 2) == 0) begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= asgr_pkg::FINAL_LOW && b <= asgr_pkg::FINAL_HIGH) ||
                   (b >= asgr_pkg::DIGIT_LOW && b <= asgr_pkg::DIGIT_HIGH) ||
                   b == asgr_pkg::PARAM_SEP);
            seq_buf.insert($urandom_range(2, seq_buf.size() - 1), b);
          end
          add_seq_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        7: begin
          // escape that is not a csi
          add_seq_byte(asgr_pkg::ESC_BYTE);
          add_seq_byte(8'($urandom_range(0, 255)));
          add_seq_byte(8'($urandom_range(0, 255)));
        end
        8: begin
          // csi with random body bytes
          add_seq_byte(asgr_pkg::ESC_BYTE);
          add_seq_byte(asgr_pkg::CSI_OPEN);
          repeat ($urandom_range(1, 8)) add_seq_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          // raw noise, escapes included
          repeat ($urandom_range(1, 6)) add_seq_byte(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0) eot_at = $urandom_range(0, seq_buf.size() - 1);
        end
      endcase
      send_seq(eot_at);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    shadow = asgr_pkg::RESET_STATE;
    rst                 <= 1'b1;
    text_if.valid       <= 1'b0;
    text_if.text_byte   <= 8'h00;
    text_if.end_of_text <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_plain_bytes();
    test_colour_set();
    test_escape_drop();
    test_eot_in_csi();
    test_random_stream();

    // drain: every owed character must come out, then the bench idles before the verdict
    text_if.valid <= 1'b0;
    rx_pattern = RX_RANDOM;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_chars.size() == 0)
      $display("tb_ansi_sgr_colour_filter_core: done, clean");
    else
      $display("tb_ansi_sgr_colour_filter_core: done, errors");
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("tb_ansi_sgr_colour_filter_core: done, errors");
    $finish;
  end

endmodule
